// ===== sv/ffpd_pkg.sv =====
// Shared constants, types and tables of the formation-following PD controller.
package ffpd_pkg;

	// Data path widths.
	localparam int POS_WIDTH    = 32;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_MAX   = 24;
	localparam int STEP_W       = $clog2(CORDIC_MAX);
	// Sine and cosine are Q2.30 values carried with headroom bits.
	localparam int TRIG_W       = 34;
	localparam int TRIG_FRAC    = 30;
	localparam int GAIN_FRAC    = 8;
	localparam int GAIN_W       = 16;
	localparam int LIMIT_W      = 31;

	localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;
	localparam logic signed [31:0] QUARTER_TURN    = 32'sh4000_0000;

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd1;
	localparam logic [2:0] REG_SPEED_LIMIT   = 3'd2;
	localparam logic [2:0] REG_TURN_LIMIT    = 3'd3;
	localparam logic [2:0] REG_SLOT_OFFSET_X = 3'd4;
	localparam logic [2:0] REG_SLOT_OFFSET_Y = 3'd5;

	typedef struct packed {
		logic [GAIN_W-1:0]           prop_gain;
		logic [GAIN_W-1:0]           deriv_gain;
		logic [LIMIT_W-1:0]          speed_limit;
		logic [LIMIT_W-1:0]          turn_limit;
		logic signed [POS_WIDTH-1:0] slot_offset_x;
		logic signed [POS_WIDTH-1:0] slot_offset_y;
	} cfg_t;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/formation_follow_pd.sv =====
// Top level of the leader-follower PD controller with its step sequencer.
// One transfer on the input channel is one control tick: own pose, leader pose,
// two validity flags and a clear flag. When both poses are valid, the block
// produces one transfer on the output channel with linear_speed and turn_rate.
// When either flag is low no result follows and the block is ready again on the
// next cycle; clear_history still zeroes the stored error in that case.
// Each heading takes one CORDIC run on the shared unit (one rotation step per
// cycle); then come 23 sequencer steps on the shared multiplier and the
// saturating adder, and then the output register is loaded once it is free.
// A new tick is taken only when the sequencer is idle again, so the block does
// not take a new tick before it is through with the last one.
// in_ready is high only while the sequencer is idle. The output register parts
// the two channels: a new tick is taken while a result waits; if the next
// result is done before the old one has been taken, the sequencer holds it.
// Reset restores the register defaults, zeroes the stored error and empties
// the output register. Registers are written over the APB-style port, which
// never inserts wait states, and should be written only while the block idles.
module formation_follow_pd (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ffpd_pkg::POS_WIDTH-1:0] own_x,
	input  logic signed [ffpd_pkg::POS_WIDTH-1:0] own_y,
	input  logic signed [15:0]                    own_heading,
	input  logic signed [ffpd_pkg::POS_WIDTH-1:0] leader_x,
	input  logic signed [ffpd_pkg::POS_WIDTH-1:0] leader_y,
	input  logic signed [15:0]                    leader_heading,
	input  logic                                  own_pose_valid,
	input  logic                                  leader_pose_valid,
	input  logic                                  clear_history,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ffpd_pkg::POS_WIDTH-1:0] linear_speed,
	output logic signed [ffpd_pkg::POS_WIDTH-1:0] turn_rate,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ffpd_pkg::ADDR_W-1:0]           paddr,
	input  logic [ffpd_pkg::DATA_W-1:0]           pwdata,
	output logic [ffpd_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);

	localparam int PW = ffpd_pkg::POS_WIDTH;
	localparam int TW = ffpd_pkg::TRIG_W;
	localparam int AW = ffpd_pkg::ANGLE_WIDTH;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LEAD = 5'b00010,
		S_OWN  = 5'b00100,
		S_CALC = 5'b01000,
		S_HOLD = 5'b10000
	} state_t;

	// Sequencer steps. A product issued in one step is taken in the next.
	typedef enum logic [4:0] {
		K_MUL_LCFX, K_MUL_LSFY, K_MUL_LSFX, K_MUL_LCFY, K_ROT_X, K_ROT_Y,
		K_TGT_X, K_TGT_Y, K_ERR_X, K_ERR_Y, K_DIF_X, K_DIF_Y, K_MUL_KPEY,
		K_VEL_X, K_CAP_KDDY, K_VEL_Y, K_MUL_OCVX, K_MUL_OSVY, K_MUL_OCVY,
		K_FWD, K_CAP_OSVX, K_LAT, K_CLAMP
	} step_t;

	ffpd_pkg::cfg_t cfg;

	state_t state_q;
	step_t  step_q;

	logic signed [TW-1:0] lc_q, ls_q, oc_q, os_q;
	logic signed [PW-1:0] t0_q, t1_q, t2_q, t3_q, pa_q, pb_q;
	logic signed [PW-1:0] own_x_q, own_y_q, lead_x_q, lead_y_q;
	logic [AW-1:0]        own_hd_q;
	logic signed [PW-1:0] last_x_q, last_y_q;
	logic signed [PW-1:0] out_lin_q, out_turn_q;
	logic                 out_valid_q;

	logic                 in_fire, go;
	logic                 cdc_start, cdc_busy, cdc_done;
	logic [AW-1:0]        cdc_angle;
	logic signed [TW-1:0] cdc_cos, cdc_sin;

	logic signed [TW-1:0] mul_a;
	logic signed [PW-1:0] mul_b, mul_res;
	logic                 mul_gain;

	logic signed [PW-1:0] add_a, add_b, add_sum;
	logic                 add_sub;

	logic signed [PW:0]   spd_lim, trn_lim, fwd_ext, lat_ext;
	logic signed [PW-1:0] fwd_clamped, lat_clamped;
	logic                 out_free;

	function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b, input logic sub);
		logic signed [PW:0] s;
		s = sub ? ({a[PW-1], a} - {b[PW-1], b}) : ({a[PW-1], a} + {b[PW-1], b});
		if (s[PW] != s[PW-1]) begin
			return s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		end
		return s[PW-1:0];
	endfunction

	function automatic logic signed [PW-1:0] clamp_lim(input logic signed [PW:0] v,
			input logic signed [PW:0] lim);
		logic signed [PW:0] r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r[PW-1:0];
	endfunction

	ffpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ffpd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cdc_start),
		.angle  (cdc_angle),
		.busy   (cdc_busy),
		.done   (cdc_done),
		.cos_v  (cdc_cos),
		.sin_v  (cdc_sin)
	);

	ffpd_mul u_mul (
		.clk        (clk),
		.a          (mul_a),
		.b          (mul_b),
		.gain_shift (mul_gain),
		.res        (mul_res)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign go       = in_fire & own_pose_valid & leader_pose_valid;

	// The leader heading goes straight from the port; the own heading is latched.
	assign cdc_start = go | ((state_q == S_LEAD) & cdc_done);
	assign cdc_angle = (state_q == S_IDLE) ? leader_heading[AW-1:0] : own_hd_q;

	assign out_free = !out_valid_q || out_ready;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_gain = 1'b0;
		if (state_q == S_CALC) begin
			case (step_q)
				K_MUL_LCFX: begin mul_a = lc_q; mul_b = cfg.slot_offset_x; end
				K_MUL_LSFY: begin mul_a = ls_q; mul_b = cfg.slot_offset_y; end
				K_MUL_LSFX: begin mul_a = ls_q; mul_b = cfg.slot_offset_x; end
				K_MUL_LCFY: begin mul_a = lc_q; mul_b = cfg.slot_offset_y; end
				K_DIF_X: begin
					mul_a = TW'(cfg.prop_gain); mul_b = t0_q; mul_gain = 1'b1;
				end
				K_DIF_Y: begin
					mul_a = TW'(cfg.deriv_gain); mul_b = t2_q; mul_gain = 1'b1;
				end
				K_MUL_KPEY: begin
					mul_a = TW'(cfg.prop_gain); mul_b = t1_q; mul_gain = 1'b1;
				end
				K_VEL_X: begin
					mul_a = TW'(cfg.deriv_gain); mul_b = t3_q; mul_gain = 1'b1;
				end
				K_MUL_OCVX: begin mul_a = oc_q; mul_b = t0_q; end
				K_MUL_OSVY: begin mul_a = os_q; mul_b = t1_q; end
				K_MUL_OCVY: begin mul_a = oc_q; mul_b = t1_q; end
				K_FWD:      begin mul_a = os_q; mul_b = t0_q; end
				default: ;
			endcase
		end
	end

	// Operand selection for the shared saturating adder.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (step_q)
			K_ROT_X: begin add_a = t0_q;     add_b = t1_q;     add_sub = 1'b1; end
			K_ROT_Y: begin add_a = t2_q;     add_b = t3_q;                     end
			K_TGT_X: begin add_a = lead_x_q; add_b = t0_q;                     end
			K_TGT_Y: begin add_a = lead_y_q; add_b = t1_q;                     end
			K_ERR_X: begin add_a = t0_q;     add_b = own_x_q;  add_sub = 1'b1; end
			K_ERR_Y: begin add_a = t1_q;     add_b = own_y_q;  add_sub = 1'b1; end
			K_DIF_X: begin add_a = t0_q;     add_b = last_x_q; add_sub = 1'b1; end
			K_DIF_Y: begin add_a = t1_q;     add_b = last_y_q; add_sub = 1'b1; end
			K_VEL_X, K_VEL_Y, K_FWD: begin add_a = pa_q; add_b = pb_q; end
			K_LAT:   begin add_a = pa_q;     add_b = pb_q;     add_sub = 1'b1; end
			default: ;
		endcase
		add_sum = sat_add(add_a, add_b, add_sub);
	end

	assign spd_lim     = (PW + 1)'(cfg.speed_limit);
	assign trn_lim     = (PW + 1)'(cfg.turn_limit);
	assign fwd_ext     = (PW + 1)'(t2_q);
	assign lat_ext     = (PW + 1)'(t3_q);
	assign fwd_clamped = clamp_lim(fwd_ext, spd_lim);
	assign lat_clamped = clamp_lim(lat_ext, trn_lim);

	// Control: state, step, stored error and the output register's valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= K_MUL_LCFX;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A result handed over replaces one that leaves in the same cycle.
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && clear_history) begin
						last_x_q <= '0;
						last_y_q <= '0;
					end
					if (go) begin
						state_q <= S_LEAD;
					end
				end
				S_LEAD: begin
					if (cdc_done) begin
						state_q <= S_OWN;
					end
				end
				S_OWN: begin
					if (cdc_done) begin
						state_q <= S_CALC;
						step_q  <= K_MUL_LCFX;
					end
				end
				S_CALC: begin
					if (step_q == K_MUL_KPEY) begin
						last_x_q <= t0_q;
						last_y_q <= t1_q;
					end
					if (step_q == K_CLAMP) begin
						state_q <= S_HOLD;
					end else begin
						step_q <= step_t'(step_q + 5'd1);
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			own_x_q  <= own_x;
			own_y_q  <= own_y;
			own_hd_q <= own_heading[AW-1:0];
			lead_x_q <= leader_x;
			lead_y_q <= leader_y;
		end
		if (state_q == S_LEAD && cdc_done) begin
			lc_q <= cdc_cos;
			ls_q <= cdc_sin;
		end
		if (state_q == S_OWN && cdc_done) begin
			oc_q <= cdc_cos;
			os_q <= cdc_sin;
		end
		if (state_q == S_HOLD && out_free) begin
			out_lin_q  <= t2_q;
			out_turn_q <= t3_q;
		end
		if (state_q == S_CALC) begin
			case (step_q)
				K_MUL_LSFY: t0_q <= mul_res;
				K_MUL_LSFX: t1_q <= mul_res;
				K_MUL_LCFY: t2_q <= mul_res;
				K_ROT_X: begin t3_q <= mul_res; t0_q <= add_sum; end
				K_ROT_Y: t1_q <= add_sum;
				K_TGT_X: t0_q <= add_sum;
				K_TGT_Y: t1_q <= add_sum;
				K_ERR_X: t0_q <= add_sum;
				K_ERR_Y: t1_q <= add_sum;
				K_DIF_X: t2_q <= add_sum;
				K_DIF_Y: begin t3_q <= add_sum; pa_q <= mul_res; end
				K_MUL_KPEY: pb_q <= mul_res;
				K_VEL_X: begin t0_q <= add_sum; pa_q <= mul_res; end
				K_CAP_KDDY: pb_q <= mul_res;
				K_VEL_Y: t1_q <= add_sum;
				K_MUL_OSVY: pa_q <= mul_res;
				K_MUL_OCVY: pb_q <= mul_res;
				K_FWD: begin t2_q <= add_sum; pa_q <= mul_res; end
				K_CAP_OSVX: pb_q <= mul_res;
				K_LAT: t3_q <= add_sum;
				K_CLAMP: begin t2_q <= fwd_clamped; t3_q <= lat_clamped; end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign linear_speed = out_lin_q;
	assign turn_rate    = out_turn_q;

	// The CORDIC unit is only started when it is free.
	a_cordic_free: assert property (@(posedge clk) disable iff (!arst_n)
		cdc_start |-> !cdc_busy)
		else $error("CORDIC started while busy");

	// A result only appears when the sequencer hands one over.
	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_HOLD))
		else $error("result appeared outside the hand-over state");

	// Delivered commands stay within the configured limits.
	a_speed_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((PW + 1)'(out_lin_q) <= spd_lim && (PW + 1)'(out_lin_q) >= -spd_lim))
		else $error("linear speed beyond its limit");

	a_turn_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((PW + 1)'(out_turn_q) <= trn_lim && (PW + 1)'(out_turn_q) >= -trn_lim))
		else $error("turn rate beyond its limit");

endmodule

// ===== sv/ffpd_regs.sv =====
// Configuration register file with an APB-style write and read port.
module ffpd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ffpd_pkg::ADDR_W-1:0]  paddr,
	input  logic [ffpd_pkg::DATA_W-1:0]  pwdata,
	output logic [ffpd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output ffpd_pkg::cfg_t               cfg
);

	ffpd_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= 16'd307;
			cfg_q.deriv_gain    <= 16'd77;
			cfg_q.speed_limit   <= 31'd32768;
			cfg_q.turn_limit    <= 31'd65536;
			cfg_q.slot_offset_x <= '0;
			cfg_q.slot_offset_y <= '0;
		end else if (wr_en) begin
			case (idx)
				ffpd_pkg::REG_PROP_GAIN:     cfg_q.prop_gain     <= pwdata[15:0];
				ffpd_pkg::REG_DERIV_GAIN:    cfg_q.deriv_gain    <= pwdata[15:0];
				ffpd_pkg::REG_SPEED_LIMIT:   cfg_q.speed_limit   <= pwdata[30:0];
				ffpd_pkg::REG_TURN_LIMIT:    cfg_q.turn_limit    <= pwdata[30:0];
				ffpd_pkg::REG_SLOT_OFFSET_X: cfg_q.slot_offset_x <= pwdata;
				ffpd_pkg::REG_SLOT_OFFSET_Y: cfg_q.slot_offset_y <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ffpd_pkg::REG_PROP_GAIN:     prdata = 32'(cfg_q.prop_gain);
			ffpd_pkg::REG_DERIV_GAIN:    prdata = 32'(cfg_q.deriv_gain);
			ffpd_pkg::REG_SPEED_LIMIT:   prdata = 32'(cfg_q.speed_limit);
			ffpd_pkg::REG_TURN_LIMIT:    prdata = 32'(cfg_q.turn_limit);
			ffpd_pkg::REG_SLOT_OFFSET_X: prdata = cfg_q.slot_offset_x;
			ffpd_pkg::REG_SLOT_OFFSET_Y: prdata = cfg_q.slot_offset_y;
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== sv/ffpd_cordic.sv =====
// Iterative CORDIC unit: one rotation step per cycle gives cosine and sine.
module ffpd_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ffpd_pkg::ANGLE_WIDTH-1:0]   angle,
	output logic                               busy,
	output logic                               done,
	output logic signed [ffpd_pkg::TRIG_W-1:0] cos_v,
	output logic signed [ffpd_pkg::TRIG_W-1:0] sin_v
);

	localparam int TW = ffpd_pkg::TRIG_W;

	logic signed [TW-1:0]               x_q, y_q, z_q;
	logic [ffpd_pkg::STEP_W-1:0]        i_q;
	logic                               busy_q, done_q, flip_q;

	logic [31:0]          ang32;
	logic signed [31:0]   ang_s;
	logic                 wide;
	logic signed [31:0]   z_init;
	logic signed [TW-1:0] xs, ys, at_v;
	logic                 last;

	assign ang32  = {angle, {(32 - ffpd_pkg::ANGLE_WIDTH){1'b0}}};
	assign ang_s  = ang32;
	// Angles beyond a quarter turn are turned by a half turn and the result negated.
	assign wide   = (ang_s > ffpd_pkg::QUARTER_TURN) || (ang_s < -ffpd_pkg::QUARTER_TURN);
	assign z_init = wide ? (ang32 ^ 32'h8000_0000) : ang32;

	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign at_v = TW'(ffpd_pkg::atan_at(i_q));
	assign last = (i_q == ffpd_pkg::STEP_W'(ffpd_pkg::CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= TW'(ffpd_pkg::CORDIC_INV_GAIN);
			y_q    <= '0;
			z_q    <= TW'(z_init);
			flip_q <= wide;
		end else if (busy_q) begin
			if (!z_q[TW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at_v;
			end
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

endmodule

// ===== sv/ffpd_mul.sv =====
// Shared multiplier with a registered product, then round half up and saturation.
module ffpd_mul (
	input  logic                                  clk,
	input  logic signed [ffpd_pkg::TRIG_W-1:0]    a,
	input  logic signed [ffpd_pkg::POS_WIDTH-1:0] b,
	input  logic                                  gain_shift,
	output logic signed [ffpd_pkg::POS_WIDTH-1:0] res
);

	localparam int PROD_W = ffpd_pkg::TRIG_W + ffpd_pkg::POS_WIDTH;
	localparam int PW     = PROD_W + 1;
	localparam logic signed [PW-1:0] HALF_GAIN = PW'(2 ** (ffpd_pkg::GAIN_FRAC - 1));
	localparam logic signed [PW-1:0] HALF_TRIG = PW'(2 ** (ffpd_pkg::TRIG_FRAC - 1));
	localparam logic signed [PW-1:0] SAT_HI =
		PW'((64'sd1 <<< (ffpd_pkg::POS_WIDTH - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     gain_s1;
	logic signed [PW-1:0]     ext, rnd, q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		gain_s1 <= gain_shift;
	end

	always_comb begin
		ext = PW'(prod_s1);
		rnd = ext + (gain_s1 ? HALF_GAIN : HALF_TRIG);
		q   = gain_s1 ? (rnd >>> ffpd_pkg::GAIN_FRAC) : (rnd >>> ffpd_pkg::TRIG_FRAC);
		if (q > SAT_HI) begin
			res = SAT_HI[ffpd_pkg::POS_WIDTH-1:0];
		end else if (q < SAT_LO) begin
			res = SAT_LO[ffpd_pkg::POS_WIDTH-1:0];
		end else begin
			res = q[ffpd_pkg::POS_WIDTH-1:0];
		end
	end

endmodule
